### hdl/vertex_affine_transform_assert.svh
// ----------------------------------------------------------------------------
// Vertex affine transform assertion macros
// Assertion wrappers for the transform block. Under synthesis they expand
// to nothing.
// ----------------------------------------------------------------------------
`ifndef VERTEX_AFFINE_TRANSFORM_ASSERT_SVH
`define VERTEX_AFFINE_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define VAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex_affine_transform: assertion failed");
`define VAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex_affine_transform: assertion failed");
`else
`define VAT_ASSERT_IMP(lbl, ante, cons)
`define VAT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/vat_pkg.sv
// ----------------------------------------------------------------------------
// Vertex affine transform package
// Word types, register indexes, trig lookup and saturation helpers.
// ----------------------------------------------------------------------------
package vat_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int TRIG_SHIFT  = 15;
	localparam int TRIG_W      = TRIG_SHIFT + 2;
	localparam int ANGLE_W     = 9;
	localparam int OPND_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * OPND_W;
	localparam int WIDE_W      = PROD_W + 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COORD_WIDTH;
	localparam int STEP_W      = 4;

	localparam logic FUNC_XFORM = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 3'd6;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] SCALE_ONE = COORD_WIDTH'(1) << FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] SCALE_HALF = WIDE_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [WIDE_W-1:0] TRIG_HALF  = WIDE_W'(1) << (TRIG_SHIFT - 1);

	typedef struct packed {
		logic                          func;
		logic signed [COORD_WIDTH-1:0] x_in;
		logic signed [COORD_WIDTH-1:0] y_in;
		logic signed [COORD_WIDTH-1:0] z_in;
		logic                          pass_end;
	} vat_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_out;
		logic signed [COORD_WIDTH-1:0] y_out;
		logic signed [COORD_WIDTH-1:0] z_out;
	} vat_out_t;

	// Quarter-wave sine, 1.0 is 32768.
	localparam int SIN_TAB [0:90] = '{
		0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
		5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
		11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
		16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
		21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
		25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
		28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
		30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
		32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
		32768
	};

	function automatic logic signed [TRIG_W-1:0] sin_lut(input logic [6:0] d);
		if (d > 7'd90)
			return '0;
		return TRIG_W'(SIN_TAB[d]);
	endfunction

	// Folds an angle below 720 into 0..359.
	function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W:0] a);
		if (a >= 10'd360)
			return ANGLE_W'(a - 10'd360);
		return a[ANGLE_W-1:0];
	endfunction

	function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANGLE_W-1:0] a);
		logic [ANGLE_W-1:0] r;
		if (a <= 9'd90) begin
			r = a;
			return sin_lut(r[6:0]);
		end else if (a <= 9'd180) begin
			r = 9'd180 - a;
			return sin_lut(r[6:0]);
		end else if (a <= 9'd270) begin
			r = a - 9'd180;
			return -sin_lut(r[6:0]);
		end
		r = 9'd360 - a;
		return -sin_lut(r[6:0]);
	endfunction

	function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [ANGLE_W-1:0] a);
		return sin_deg(wrap_deg({1'b0, a} + 10'd90));
	endfunction

	function automatic logic signed [WIDE_W-1:0] wide(input logic signed [COORD_WIDTH-1:0] v);
		return WIDE_W'(v);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
		input logic signed [WIDE_W-1:0] v
	);
		logic [WIDE_W-COORD_WIDTH:0] top;
		top = v[WIDE_W-1:COORD_WIDTH-1];
		if (top == '0 || top == '1)
			return v[COORD_WIDTH-1:0];
		return v[WIDE_W-1] ? COORD_MIN : COORD_MAX;
	endfunction

endpackage

### hdl/vertex_affine_transform.sv
// ----------------------------------------------------------------------------
// Vertex affine transform
// Scales, moves and rotates (X, then Y, then Z about the moved center) one
// Q16.16 vertex per word, with one shared multiplier under a step sequencer.
//
//   channel | direction | handshake          | word
//   vtx     | in        | vtx_valid/vtx_stall | vat_in_t
//   res     | out       | res_valid/res_stall | vat_out_t
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A transform word holds vtx_stall from acceptance until its result is loaded:
// the single 33x33 multiplier works through 15 products (three scales, four
// per rotation), then ST_DRAIN finishes the last product and ST_DONE loads the
// result register unless the last result is stalled. A clear word gives no result.
// The result register lets a new word start while res_stall holds the last
// result. Reset clears the center, the state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "vertex_affine_transform_assert.svh"

module vertex_affine_transform (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  vtx_valid,
	output logic                                  vtx_stall,
	input  vat_pkg::vat_in_t                      vtx,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output vat_pkg::vat_out_t                     res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vat_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vat_pkg::CFG_DATA_W-1:0]        cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;
	typedef enum logic [1:0] {COEF_K, COEF_C, COEF_S, COEF_NS} coef_t;
	typedef enum logic [1:0] {WB_SCALE, WB_LOAD, WB_FIRST, WB_LAST} wb_t;
	typedef enum logic [1:0] {CRD_X, CRD_Y, CRD_Z} crd_t;

	typedef struct packed {
		crd_t  src;
		coef_t coef;
		wb_t   wb;
		crd_t  a_idx;
		crd_t  b_idx;
	} op_t;

	localparam logic [vat_pkg::STEP_W-1:0] STEP_X_END = 4'd6;
	localparam logic [vat_pkg::STEP_W-1:0] STEP_Y_END = 4'd10;
	localparam logic [vat_pkg::STEP_W-1:0] LAST_STEP  = 4'd14;

	// Four products of one rotation in plane (a, b). With b_first the two
	// products of each output swap order, so the coordinate written by the
	// previous rotation is read in the step after, once its writeback has landed.
	function automatic op_t rot_op(input crd_t a, input crd_t b, input logic b_first,
		input logic [1:0] j);
		op_t op;
		op.a_idx = a;
		op.b_idx = b;
		unique case (j)
			2'd0: begin
				op.src  = b_first ? b : a;
				op.coef = b_first ? COEF_NS : COEF_C;
				op.wb   = WB_LOAD;
			end
			2'd1: begin
				op.src  = b_first ? a : b;
				op.coef = b_first ? COEF_C : COEF_NS;
				op.wb   = WB_FIRST;
			end
			2'd2: begin
				op.src  = b_first ? b : a;
				op.coef = b_first ? COEF_C : COEF_S;
				op.wb   = WB_LOAD;
			end
			default: begin
				op.src  = b_first ? a : b;
				op.coef = b_first ? COEF_S : COEF_C;
				op.wb   = WB_LAST;
			end
		endcase
		return op;
	endfunction

	function automatic op_t decode(input logic [vat_pkg::STEP_W-1:0] st);
		op_t op;
		op = '{src: CRD_X, coef: COEF_K, wb: WB_SCALE, a_idx: CRD_X, b_idx: CRD_X};
		unique case (st)
			4'd0: begin
				op.src   = CRD_X;
				op.a_idx = CRD_X;
			end
			4'd1: begin
				op.src   = CRD_Y;
				op.a_idx = CRD_Y;
			end
			4'd2: begin
				op.src   = CRD_Z;
				op.a_idx = CRD_Z;
			end
			4'd3:  op = rot_op(CRD_Y, CRD_Z, 1'b0, 2'd0);
			4'd4:  op = rot_op(CRD_Y, CRD_Z, 1'b0, 2'd1);
			4'd5:  op = rot_op(CRD_Y, CRD_Z, 1'b0, 2'd2);
			4'd6:  op = rot_op(CRD_Y, CRD_Z, 1'b0, 2'd3);
			4'd7:  op = rot_op(CRD_X, CRD_Z, 1'b0, 2'd0);
			4'd8:  op = rot_op(CRD_X, CRD_Z, 1'b0, 2'd1);
			4'd9:  op = rot_op(CRD_X, CRD_Z, 1'b0, 2'd2);
			4'd10: op = rot_op(CRD_X, CRD_Z, 1'b0, 2'd3);
			4'd11: op = rot_op(CRD_X, CRD_Y, 1'b1, 2'd0);
			4'd12: op = rot_op(CRD_X, CRD_Y, 1'b1, 2'd1);
			4'd13: op = rot_op(CRD_X, CRD_Y, 1'b1, 2'd2);
			4'd14: op = rot_op(CRD_X, CRD_Y, 1'b1, 2'd3);
			default: ;
		endcase
		return op;
	endfunction

	function automatic logic signed [vat_pkg::COORD_WIDTH-1:0] pick(input crd_t i,
		input logic signed [vat_pkg::COORD_WIDTH-1:0] a,
		input logic signed [vat_pkg::COORD_WIDTH-1:0] b,
		input logic signed [vat_pkg::COORD_WIDTH-1:0] c);
		unique case (i)
			CRD_X:   return a;
			CRD_Y:   return b;
			default: return c;
		endcase
	endfunction

	state_t                                  state_q;
	logic [vat_pkg::STEP_W-1:0]              step_q;
	logic                                    vld_s1;
	op_t                                     op_s1;
	logic signed [vat_pkg::PROD_W-1:0]       prod_s1;
	logic signed [vat_pkg::PROD_W-1:0]       acc_q;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  tmp_q;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  x_q, y_q, z_q;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  ex_q, ey_q, ez_q;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  pivot_x_q, pivot_y_q, pivot_z_q;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  scale_q, move_x_q, move_y_q, move_z_q;
	logic [vat_pkg::ANGLE_W-1:0]             angle_x_q, angle_y_q, angle_z_q;
	logic signed [vat_pkg::TRIG_W-1:0]       sin_q, cos_q;
	logic                                    res_valid_q;
	vat_pkg::vat_out_t                       res_q;

	logic                                    accept, xform, clear;
	op_t                                     cur_op;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  k_val, opnd_crd, opnd_ctr;
	logic signed [vat_pkg::OPND_W-1:0]       opnd, coef;
	logic signed [vat_pkg::PROD_W-1:0]       mul;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  e_x, e_y, e_z;
	logic [vat_pkg::ANGLE_W-1:0]             ang_sel, ang_w;
	logic                                    trig_ld;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  wb_move, scl_val, scl_mov, rot_ctr, rot_val;
	logic signed [vat_pkg::WIDE_W-1:0]       scl_sum, rot_sum;
	logic                                    is_scl, is_last;
	logic                                    wr_x, wr_y, wr_z;
	logic signed [vat_pkg::COORD_WIDTH-1:0]  nx, ny, nz;

	assign vtx_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign accept = vtx_valid && !vtx_stall;
	assign xform  = accept && (vtx.func == vat_pkg::FUNC_XFORM);
	assign clear  = accept && (vtx.func == vat_pkg::FUNC_CLEAR);

	// Moved center, taken once per word.
	assign e_x = vat_pkg::sat_coord(vat_pkg::wide(pivot_x_q) + vat_pkg::wide(move_x_q));
	assign e_y = vat_pkg::sat_coord(vat_pkg::wide(pivot_y_q) + vat_pkg::wide(move_y_q));
	assign e_z = vat_pkg::sat_coord(vat_pkg::wide(pivot_z_q) + vat_pkg::wide(move_z_q));

	// Shared multiplier operands.
	assign cur_op   = decode(step_q);
	assign k_val    = (scale_q == '0) ? vat_pkg::SCALE_ONE : scale_q;
	assign opnd_crd = pick(cur_op.src, x_q, y_q, z_q);
	assign opnd_ctr = pick(cur_op.src, ex_q, ey_q, ez_q);
	assign opnd     = (cur_op.coef == COEF_K) ? vat_pkg::OPND_W'(opnd_crd)
		: (vat_pkg::OPND_W'(opnd_crd) - vat_pkg::OPND_W'(opnd_ctr));

	always_comb begin
		unique case (cur_op.coef)
			COEF_K:  coef = vat_pkg::OPND_W'(k_val);
			COEF_C:  coef = vat_pkg::OPND_W'(cos_q);
			COEF_S:  coef = vat_pkg::OPND_W'(sin_q);
			default: coef = -vat_pkg::OPND_W'(sin_q);
		endcase
	end

	assign mul = opnd * coef;

	// Trig for the next rotation loads as the current one issues its last product.
	always_comb begin
		if (state_q == ST_IDLE)
			ang_sel = angle_x_q;
		else if (step_q == STEP_X_END)
			ang_sel = angle_y_q;
		else
			ang_sel = angle_z_q;
	end

	assign ang_w   = vat_pkg::wrap_deg({1'b0, ang_sel});
	assign trig_ld = xform
		|| (state_q == ST_RUN && (step_q == STEP_X_END || step_q == STEP_Y_END));

	// Writeback of the registered product.
	assign wb_move = pick(op_s1.a_idx, move_x_q, move_y_q, move_z_q);
	assign scl_sum = vat_pkg::WIDE_W'(prod_s1) + vat_pkg::SCALE_HALF;
	assign scl_val = vat_pkg::sat_coord(scl_sum >>> vat_pkg::FRAC_BITS);
	assign scl_mov = vat_pkg::sat_coord(vat_pkg::wide(scl_val) + vat_pkg::wide(wb_move));
	assign rot_sum = vat_pkg::WIDE_W'(acc_q) + vat_pkg::WIDE_W'(prod_s1) + vat_pkg::TRIG_HALF;
	assign rot_ctr = pick((op_s1.wb == WB_FIRST) ? op_s1.a_idx : op_s1.b_idx, ex_q, ey_q, ez_q);
	assign rot_val = vat_pkg::sat_coord((rot_sum >>> vat_pkg::TRIG_SHIFT)
		+ vat_pkg::wide(rot_ctr));

	assign is_scl  = vld_s1 && (op_s1.wb == WB_SCALE);
	assign is_last = vld_s1 && (op_s1.wb == WB_LAST);

	// The last product of a rotation writes b and moves the held a' into place.
	assign wr_x = ((is_scl || is_last) && op_s1.a_idx == CRD_X) || (is_last && op_s1.b_idx == CRD_X);
	assign wr_y = ((is_scl || is_last) && op_s1.a_idx == CRD_Y) || (is_last && op_s1.b_idx == CRD_Y);
	assign wr_z = ((is_scl || is_last) && op_s1.a_idx == CRD_Z) || (is_last && op_s1.b_idx == CRD_Z);
	assign nx = (is_last && op_s1.b_idx == CRD_X) ? rot_val : (is_scl ? scl_mov : tmp_q);
	assign ny = (is_last && op_s1.b_idx == CRD_Y) ? rot_val : (is_scl ? scl_mov : tmp_q);
	assign nz = (is_last && op_s1.b_idx == CRD_Z) ? rot_val : (is_scl ? scl_mov : tmp_q);

	always_ff @(posedge clk) begin
		if (xform) begin
			x_q  <= vtx.x_in;
			y_q  <= vtx.y_in;
			z_q  <= vtx.z_in;
			ex_q <= e_x;
			ey_q <= e_y;
			ez_q <= e_z;
		end else begin
			if (wr_x)
				x_q <= nx;
			if (wr_y)
				y_q <= ny;
			if (wr_z)
				z_q <= nz;
		end
		if (trig_ld) begin
			sin_q <= vat_pkg::sin_deg(ang_w);
			cos_q <= vat_pkg::cos_deg(ang_w);
		end
		if (state_q == ST_RUN) begin
			prod_s1 <= mul;
			op_s1   <= cur_op;
		end
		if (vld_s1 && op_s1.wb == WB_LOAD)
			acc_q <= prod_s1;
		if (vld_s1 && op_s1.wb == WB_FIRST)
			tmp_q <= rot_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			vld_s1      <= 1'b0;
			pivot_x_q   <= '0;
			pivot_y_q   <= '0;
			pivot_z_q   <= '0;
			scale_q     <= vat_pkg::SCALE_ONE;
			move_x_q    <= '0;
			move_y_q    <= '0;
			move_z_q    <= '0;
			angle_x_q   <= '0;
			angle_y_q   <= '0;
			angle_z_q   <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					vat_pkg::REG_SCALE:   scale_q   <= cfg_data;
					vat_pkg::REG_MOVE_X:  move_x_q  <= cfg_data;
					vat_pkg::REG_MOVE_Y:  move_y_q  <= cfg_data;
					vat_pkg::REG_MOVE_Z:  move_z_q  <= cfg_data;
					vat_pkg::REG_ANGLE_X: angle_x_q <= cfg_data[vat_pkg::ANGLE_W-1:0];
					vat_pkg::REG_ANGLE_Y: angle_y_q <= cfg_data[vat_pkg::ANGLE_W-1:0];
					vat_pkg::REG_ANGLE_Z: angle_z_q <= cfg_data[vat_pkg::ANGLE_W-1:0];
					default: ;
				endcase
			end

			// The pass center is known at acceptance, so it is stored right away.
			if (clear) begin
				pivot_x_q <= '0;
				pivot_y_q <= '0;
				pivot_z_q <= '0;
			end else if (xform && vtx.pass_end) begin
				pivot_x_q <= e_x;
				pivot_y_q <= e_y;
				pivot_z_q <= e_z;
			end

			vld_s1 <= (state_q == ST_RUN);

			// In ST_DONE the result register is handled by the state machine below.
			if (res_valid_q && !res_stall && state_q != ST_DONE)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (xform) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + vat_pkg::STEP_W'(1);
					if (step_q == LAST_STEP)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q       <= '{x_out: x_q, y_out: y_q, z_out: z_q};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`VAT_ASSERT_NEXT(a_clear_zeroes_center, clear, state_q == ST_IDLE && pivot_x_q == '0 && pivot_y_q == '0 && pivot_z_q == '0)
	`VAT_ASSERT_NEXT(a_xform_starts_run, xform, state_q == ST_RUN && step_q == '0)
	`VAT_ASSERT_IMP(a_step_in_range, state_q == ST_RUN, step_q <= LAST_STEP)
	`VAT_ASSERT_IMP(a_drain_last_product, state_q == ST_DRAIN, vld_s1 && op_s1.wb == WB_LAST)

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Vertex affine transform testbench
// Sends vertex and clear words with random gaps while the result side stalls
// at random. Every expected result comes from a separate fixed-point model of
// scale, move and the three rotations about the moved center. Each returned
// word is checked field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;
	import vat_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam int SETTLE      = 40;
	localparam int LIMIT       = 500000;
	localparam int PHASES      = 9;
	localparam int PHASE_WORDS = 104;
	localparam int IDLE_PCT    = 31;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam wide_t TOP = 128'sd2147483647;
	localparam wide_t BOT = -128'sd2147483648;

	localparam int SINE_Q15 [0:90] = '{
		0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
		5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
		11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
		16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
		21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
		25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
		28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
		30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
		32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
		32768
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  vtx_valid = 1'b0;
	logic                  vtx_stall;
	vat_in_t               vtx = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	vat_out_t              res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Copy of the register file and of the kept center.
	coord_t             scale_r, mx_r, my_r, mz_r;
	logic [ANGLE_W-1:0] ax_r, ay_r, az_r;
	coord_t             pivot_x, pivot_y, pivot_z;

	vat_in_t     vertex_q[$];
	vat_out_t    xform_q[$];
	int          errors = 0;
	bit          no_gaps = 1'b0;
	int unsigned cycles = 0;

	vertex_affine_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #2 clk = ~clk;

	function automatic coord_t clamp(input wide_t v);
		if (v > TOP)
			return COORD_MAX;
		if (v < BOT)
			return COORD_MIN;
		return v[COORD_WIDTH-1:0];
	endfunction

	// Round half up, then arithmetic shift.
	function automatic wide_t round_shift(input wide_t v, input int sh);
		return (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic int sine_deg(input int d);
		if (d <= 90)
			return SINE_Q15[d];
		if (d <= 180)
			return SINE_Q15[180 - d];
		if (d <= 270)
			return -SINE_Q15[d - 180];
		return -SINE_Q15[360 - d];
	endfunction

	task automatic rotate_pair(inout coord_t a, inout coord_t b, input coord_t ca,
			input coord_t cb, input logic [ANGLE_W-1:0] ang);
		int    deg;
		wide_t s, c, t, u;
		deg = ang;
		if (deg >= 360)
			deg -= 360;
		s = sine_deg(deg);
		c = sine_deg((deg + 90) % 360);
		t = wide_t'(a) * c - wide_t'(ca) * c - wide_t'(b) * s + wide_t'(cb) * s;
		u = wide_t'(a) * s - wide_t'(ca) * s + wide_t'(b) * c - wide_t'(cb) * c;
		a = clamp(round_shift(t, TRIG_SHIFT) + wide_t'(ca));
		b = clamp(round_shift(u, TRIG_SHIFT) + wide_t'(cb));
	endtask

	function automatic coord_t scaled_plus(input coord_t v, input coord_t k, input coord_t m);
		coord_t s;
		s = clamp(round_shift(wide_t'(v) * wide_t'(k), FRAC_BITS));
		return clamp(wide_t'(s) + wide_t'(m));
	endfunction

	// Applies one accepted word to the center and queues its expected result.
	task automatic accept_word(input vat_in_t w);
		coord_t   k, x, y, z, ex, ey, ez;
		vat_out_t r;
		if (w.func == FUNC_CLEAR) begin
			pivot_x = '0;
			pivot_y = '0;
			pivot_z = '0;
		end else begin
			k = (scale_r == '0) ? SCALE_ONE : scale_r;
			x = scaled_plus(w.x_in, k, mx_r);
			y = scaled_plus(w.y_in, k, my_r);
			z = scaled_plus(w.z_in, k, mz_r);
			ex = clamp(wide_t'(pivot_x) + wide_t'(mx_r));
			ey = clamp(wide_t'(pivot_y) + wide_t'(my_r));
			ez = clamp(wide_t'(pivot_z) + wide_t'(mz_r));
			rotate_pair(y, z, ey, ez, ax_r);
			rotate_pair(x, z, ex, ez, ay_r);
			rotate_pair(x, y, ex, ey, az_r);
			if (w.pass_end) begin
				pivot_x = ex;
				pivot_y = ey;
				pivot_z = ez;
			end
			r.x_out = x;
			r.y_out = y;
			r.z_out = z;
			xform_q = {xform_q, r};
		end
	endtask

	task automatic check_result(input vat_out_t got);
		vat_out_t want;
		if (xform_q.size() == 0) begin
			$error("unexpected result word: x_out=%0d y_out=%0d z_out=%0d",
				got.x_out, got.y_out, got.z_out);
			errors++;
		end else begin
			want = xform_q.pop_front();
			if (got.x_out !== want.x_out) begin
				$error("x_out: expected %0d, got %0d", want.x_out, got.x_out);
				errors++;
			end
			if (got.y_out !== want.y_out) begin
				$error("y_out: expected %0d, got %0d", want.y_out, got.y_out);
				errors++;
			end
			if (got.z_out !== want.z_out) begin
				$error("z_out: expected %0d, got %0d", want.z_out, got.z_out);
				errors++;
			end
		end
	endtask

	// Vertex driver. A held word stays unchanged until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_valid <= 1'b0;
			vtx <= '0;
			pivot_x = '0;
			pivot_y = '0;
			pivot_z = '0;
		end else begin : drive
			logic holding;
			holding = vtx_valid;
			if (vtx_valid && !vtx_stall) begin
				accept_word(vtx);
				holding = 1'b0;
			end
			if (!holding) begin
				if (vertex_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					vtx <= vertex_q.pop_front();
					vtx_valid <= 1'b1;
				end else begin
					vtx_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall)
				check_result(res);
			res_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_r <= SCALE_ONE;
			mx_r <= '0;
			my_r <= '0;
			mz_r <= '0;
			ax_r <= '0;
			ay_r <= '0;
			az_r <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCALE:   scale_r <= cfg_data;
				REG_MOVE_X:  mx_r <= cfg_data;
				REG_MOVE_Y:  my_r <= cfg_data;
				REG_MOVE_Z:  mz_r <= cfg_data;
				REG_ANGLE_X: ax_r <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_Y: ay_r <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_Z: az_r <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4, 5: return coord_t'($urandom_range(0, 32'h1FFFFF)) - coord_t'(32'h100000);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t rand_scale();
		case ($urandom_range(7))
			0: return '0;
			1: return SCALE_ONE;
			2: return COORD_MIN;
			3: return COORD_MAX;
			4, 5: return coord_t'($urandom_range(0, 32'h7FFFF)) - coord_t'(32'h40000);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic int rand_deg();
		case ($urandom_range(9))
			0: return 0;
			1: return 90 * $urandom_range(3);
			2: return 360 + $urandom_range(151);
			3: return 359;
			default: return $urandom_range(359);
		endcase
	endfunction

	// Angle registers only keep the low bits, so the rest is random.
	function automatic logic [31:0] angle_word(input int deg);
		return ($urandom & ~32'h1FF) | 32'(deg);
	endfunction

	task automatic push_vertex(input coord_t x, input coord_t y, input coord_t z,
			input logic last);
		vat_in_t w;
		w.func = FUNC_XFORM;
		w.x_in = x;
		w.y_in = y;
		w.z_in = z;
		w.pass_end = last;
		vertex_q = {vertex_q, w};
	endtask

	task automatic push_clear();
		vat_in_t w;
		w.func = FUNC_CLEAR;
		w.x_in = $urandom;
		w.y_in = $urandom;
		w.z_in = $urandom;
		w.pass_end = $urandom_range(1);
		vertex_q = {vertex_q, w};
	endtask

	// Waits until every word is taken and answered, then lets a clear finish.
	task automatic drain();
		while (vertex_q.size() != 0 || vtx_valid || xform_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_config(input logic [31:0] k, input logic [31:0] mx,
			input logic [31:0] my, input logic [31:0] mz, input logic [31:0] ax,
			input logic [31:0] ay, input logic [31:0] az, input bit poke_none);
		drain();
		write_reg(REG_SCALE, k);
		write_reg(REG_MOVE_X, mx);
		write_reg(REG_MOVE_Y, my);
		write_reg(REG_MOVE_Z, mz);
		write_reg(REG_ANGLE_X, ax);
		write_reg(REG_ANGLE_Y, ay);
		write_reg(REG_ANGLE_Z, az);
		if (poke_none)
			write_reg(REG_NONE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: extremes, a pass end and a clear.
		push_vertex('0, '0, '0, 1'b0);
		push_vertex(COORD_MAX, COORD_MIN, 1, 1'b0);
		push_vertex(COORD_MIN, COORD_MAX, -1, 1'b1);
		push_clear();
		push_vertex(32'sh10000, -32'sh10000, 32'sd12345, 1'b1);

		// Most negative scale with full moves saturates nearly everywhere.
		load_config(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, angle_word(359),
			angle_word(1), angle_word(180), 1'b0);
		push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		push_vertex(1, -1, '0, 1'b0);
		push_vertex(32'sh7FFF, '0, -32'sh8000, 1'b1);

		// Zero scale means one; angles past 359 wrap; index 7 goes nowhere.
		load_config('0, 32'h30000, -32'sh28000, 32'h7FFF0000, angle_word(360),
			angle_word(511), angle_word(90), 1'b1);
		push_vertex(32'sh10000, 32'sh20000, 32'sh30000, 1'b1);
		push_vertex(-32'sh50000, 32'sh8000, 1, 1'b0);
		push_clear();
		push_vertex(32'sh12345678, -32'sh12345678, 32'sh40000000, 1'b0);

		load_config(COORD_MAX, '0, '0, '0, angle_word(45), angle_word(270),
			angle_word(135), 1'b0);
		push_vertex(32'sh10000, 32'sh20000, -32'sh10000, 1'b0);
		push_vertex(COORD_MIN, 1, COORD_MAX, 1'b1);
		push_vertex(32'sh8000, 32'sh8000, 32'sh8000, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			load_config(rand_scale(), rand_coord(), rand_coord(), rand_coord(),
				angle_word(rand_deg()), angle_word(rand_deg()), angle_word(rand_deg()),
				$urandom_range(3) == 0);
			// One phase runs with neither side ever pausing.
			no_gaps = (p == 4);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(99) < 5)
					push_clear();
				else
					push_vertex(rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(7) == 0);
			end
		end

		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
